FILE: rtl/core/idsa_pkg.sv
// package for the interval distinct slot assigner
// holds sizes, payload structs and the sort order function; no dependencies
package idsa_pkg;
   localparam int MAX_EVENTS = 64;
   localparam int DATE_BITS  = 24;
   localparam int IDX_BITS   = $clog2(MAX_EVENTS);
   localparam int CNT_BITS   = IDX_BITS + 1;

   typedef struct packed {
      logic [23:0] start_date;
      logic [23:0] end_date;
      logic        last_event;
   } req_type;

   typedef struct packed {
      logic [5:0]  event_index;
      logic [23:0] assigned_date;
      logic        no_free_date;
      logic        last_result;
   } rsp_type;

   // true when window a is handled before window b
   function automatic logic goes_before(input logic [DATE_BITS-1:0] sa,
                                        input logic [DATE_BITS-1:0] ea,
                                        input logic [IDX_BITS-1:0]  ia,
                                        input logic [DATE_BITS-1:0] sb,
                                        input logic [DATE_BITS-1:0] eb,
                                        input logic [IDX_BITS-1:0]  ib);
      logic r;
      if (ea != eb)      r = ea < eb;
      else if (sa != sb) r = sa < sb;
      else               r = ia < ib;
      return r;
   endfunction
endpackage

FILE: rtl/core/interval_distinct_slot_assigner_core.sv
// top level of the interval distinct slot assigner
// uses idsa_pkg; window, order, taken and answer memories are inside this module
//
//  channel | ports                        | transfer
//  request | start, busy, req_payload     | start high while busy low
//  result  | rsp_strobe, rsp_payload      | every cycle rsp_strobe is high
//
// windows load one per cycle. after the last window (or the 64th) the block
// goes busy: a rank pass orders the windows, then each window is fetched
// (order read, then window read) and its scan tests candidate dates, each date
// costing one pass over the taken list (one entry a cycle), then n results
// leave one at a time.
// reset is synchronous and clears only control state. results cannot be stalled.
module interval_distinct_slot_assigner_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  idsa_pkg::req_type   req_payload,
   output logic                rsp_strobe,
   output idsa_pkg::rsp_type   rsp_payload
);
   import idsa_pkg::*;

   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_RANKA = 7'b0000010,
      S_RANKB = 7'b0000100,
      S_PICK  = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_EMITW = 7'b1000000
   } state_type;

   // memories
   logic [2*DATE_BITS-1:0] win_mem   [MAX_EVENTS];
   logic [IDX_BITS-1:0]    order_mem [MAX_EVENTS];
   logic [DATE_BITS-1:0]   taken_mem [MAX_EVENTS];
   logic [DATE_BITS:0]     ans_mem   [MAX_EVENTS];

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;     // windows loaded
   logic [CNT_BITS-1:0]  i_ff, i_in;             // outer index
   logic [CNT_BITS-1:0]  j_ff, j_in;             // inner index
   logic [IDX_BITS-1:0]  rank_ff, rank_in;
   logic [CNT_BITS-1:0]  used_ff, used_in;
   logic [DATE_BITS-1:0] d_ff, d_in;             // candidate date
   logic [DATE_BITS-1:0] e_ff, e_in;
   logic [DATE_BITS-1:0] si_ff, si_in;           // ranked window copy
   logic [DATE_BITS-1:0] ei_ff, ei_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   // memory ports
   logic [IDX_BITS-1:0]    win_raddr;
   logic [2*DATE_BITS-1:0] win_rdata;
   logic                   win_we;
   logic [IDX_BITS-1:0]    win_waddr;
   logic [IDX_BITS-1:0]    ord_raddr, ord_waddr;
   logic [IDX_BITS-1:0]    ord_rdata, ord_wdata;
   logic                   ord_we;
   logic [IDX_BITS-1:0]    tk_raddr;
   logic [DATE_BITS-1:0]   tk_rdata;
   logic                   tk_we;
   logic [DATE_BITS:0]     ans_rdata, ans_wdata;
   logic [IDX_BITS-1:0]    ans_raddr, ans_waddr;
   logic                   ans_we;

   logic [DATE_BITS-1:0] rd_s, rd_e;
   assign rd_s = win_rdata[2*DATE_BITS-1:DATE_BITS];
   assign rd_e = win_rdata[DATE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_waddr] <= {req_payload.start_date[DATE_BITS-1:0],
                                         req_payload.end_date[DATE_BITS-1:0]};
      win_rdata <= win_mem[win_raddr];
      if (ord_we) order_mem[ord_waddr] <= ord_wdata;
      ord_rdata <= order_mem[ord_raddr];
      if (tk_we) taken_mem[used_ff[IDX_BITS-1:0]] <= d_ff;
      tk_rdata <= taken_mem[tk_raddr];
      if (ans_we) ans_mem[ans_waddr] <= ans_wdata;
      ans_rdata <= ans_mem[ans_raddr];
   end

   assign busy = (state_ff != S_LOAD);
   logic accept;
   assign accept = start && !busy;

   // main sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; i_in = i_ff; j_in = j_ff;
      rank_in = rank_ff; used_in = used_ff; d_in = d_ff; e_in = e_ff;
      si_in = si_ff; ei_in = ei_ff; hit_in = hit_ff;
      rsp_strobe_in = 1'b0; rsp_in = rsp_ff;
      win_we = 1'b0; win_waddr = count_ff[IDX_BITS-1:0];
      win_raddr = i_ff[IDX_BITS-1:0];
      ord_we = 1'b0; ord_waddr = rank_ff; ord_wdata = i_ff[IDX_BITS-1:0];
      ord_raddr = i_ff[IDX_BITS-1:0];
      tk_we = 1'b0; tk_raddr = j_ff[IDX_BITS-1:0];
      ans_we = 1'b0; ans_waddr = ord_rdata; ans_wdata = '0;
      ans_raddr = i_ff[IDX_BITS-1:0];
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               win_we = 1'b1;
               if (req_payload.last_event ||
                   count_ff == CNT_BITS'(MAX_EVENTS - 1)) begin
                  count_in = count_ff + 1'b1;
                  i_in = '0; j_in = '0; rank_in = '0;
                  state_in = S_RANKA;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         // read window i, then compare every j against it; rank = number before
         S_RANKA: begin
            win_raddr = i_ff[IDX_BITS-1:0];
            if (hit_ff) begin
               si_in = rd_s; ei_in = rd_e; hit_in = 1'b0;
               j_in = '0; state_in = S_RANKB;
               win_raddr = '0;
            end else begin
               hit_in = 1'b1;
            end
         end
         S_RANKB: begin
            // win_rdata holds window j-1 once j > 0
            win_raddr = j_ff[IDX_BITS-1:0];
            if (j_ff != '0 && goes_before(rd_s, rd_e, IDX_BITS'(j_ff - 1'b1),
                                          si_ff, ei_ff, i_ff[IDX_BITS-1:0]))
               rank_in = rank_ff + 1'b1;
            if (j_ff == count_ff) begin
               ord_we = 1'b1; ord_waddr = rank_in; ord_wdata = i_ff[IDX_BITS-1:0];
               rank_in = '0;
               if (i_ff + 1'b1 == count_ff) begin
                  i_in = '0; used_in = '0; hit_in = 1'b0; state_in = S_PICK;
               end else begin
                  i_in = i_ff + 1'b1; state_in = S_RANKA;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         // fetch sorted window i: order read, then window read
         S_PICK: begin
            ord_raddr = i_ff[IDX_BITS-1:0];
            win_raddr = ord_rdata;
            if (!hit_ff) begin
               hit_in = 1'b1; j_in = '0;
            end else if (j_ff == '0) begin
               j_in = CNT_BITS'(1);
            end else begin
               d_in = rd_s; e_in = rd_e; j_in = '0; hit_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         // test candidate d against taken list; tk_rdata holds entry j-1 once j > 0
         // hit_ff here marks a window whose last date was found taken
         S_SCAN: begin
            ord_raddr = i_ff[IDX_BITS-1:0];
            tk_raddr = j_ff[IDX_BITS-1:0];
            if (d_ff > e_ff || hit_ff) begin
               ans_we = 1'b1; ans_wdata = {1'b1, {DATE_BITS{1'b0}}};
               i_in = i_ff + 1'b1; j_in = '0; hit_in = 1'b0;
               state_in = (i_ff + 1'b1 == count_ff) ? S_EMIT : S_PICK;
            end else if (j_ff != '0 && tk_rdata == d_ff) begin
               // no date past the window end, so the count cannot wrap
               if (d_ff == e_ff) hit_in = 1'b1;
               else d_in = d_ff + 1'b1;
               j_in = '0;
            end else if (j_ff == used_ff) begin
               ans_we = 1'b1; ans_wdata = {1'b0, d_ff};
               tk_we = 1'b1; used_in = used_ff + 1'b1;
               i_in = i_ff + 1'b1; j_in = '0; hit_in = 1'b0;
               state_in = (i_ff + 1'b1 == count_ff) ? S_EMIT : S_PICK;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (state_in != S_SCAN && state_ff == S_SCAN && i_in == count_ff)
               i_in = '0;
         end
         S_EMIT: begin
            ans_raddr = i_ff[IDX_BITS-1:0];
            state_in = S_EMITW;
         end
         S_EMITW: begin
            ans_raddr = i_ff[IDX_BITS-1:0];
            rsp_strobe_in = 1'b1;
            rsp_in.event_index   = 6'(i_ff);
            rsp_in.assigned_date = 24'(ans_rdata[DATE_BITS-1:0]);
            rsp_in.no_free_date  = ans_rdata[DATE_BITS];
            rsp_in.last_result   = (i_ff + 1'b1 == count_ff);
            if (i_ff + 1'b1 == count_ff) begin
               count_in = '0; state_in = S_LOAD;
            end else begin
               i_in = i_ff + 1'b1; state_in = S_EMIT;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; i_ff <= '0; j_ff <= '0;
         rank_ff <= '0; used_ff <= '0; hit_ff <= 1'b0; rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; i_ff <= i_in; j_ff <= j_in;
         rank_ff <= rank_in; used_ff <= used_in; hit_ff <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      d_ff <= d_in; e_ff <= e_in; si_ff <= si_in; ei_ff <= ei_in; rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> busy) else $error("busy low outside load");
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_EMITW) else $error("stray result");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_result) |-> !busy)
      else $error("still busy after last result");
`endif
endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for interval_distinct_slot_assigner_core
// depends on idsa_pkg and the core; predicts answers per window set and checks each result
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import idsa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   req_type pending_windows[$];
   rsp_type due_answers[$];
   logic [23:0] set_starts[$];
   logic [23:0] set_ends[$];
   int   idle_left;
   int   cycle_count;
   bit   failed;

   interval_distinct_slot_assigner_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ordering rule: end date, then start date, then arrival index
   function automatic bit ranks_first(int a, int b);
      if (set_ends[a] != set_ends[b]) return set_ends[a] < set_ends[b];
      if (set_starts[a] != set_starts[b]) return set_starts[a] < set_starts[b];
      return a < b;
   endfunction

   // greedy distinct date assignment over the collected set
   task automatic assign_dates();
      int          order[$];
      longint      taken[$];
      longint      answer_date[64];
      bit          answer_fail[64];
      int          n;
      int          key;
      int          j;
      int          w;
      longint      d;
      bit          found;
      bit          hit;
      rsp_type     r;
      n = set_starts.size();
      for (int i = 0; i < n; i++) order.push_back(i);
      for (int i = 1; i < n; i++) begin
         key = order[i];
         j = i;
         while (j > 0 && ranks_first(key, order[j-1])) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end
      for (int i = 0; i < n; i++) begin
         w = order[i];
         d = set_starts[w];
         found = 1'b0;
         while (d <= longint'(set_ends[w]) && !found) begin
            hit = 1'b0;
            foreach (taken[k]) if (taken[k] == d) hit = 1'b1;
            if (!hit) found = 1'b1;
            else d++;
         end
         answer_fail[w] = !found;
         answer_date[w] = found ? d : 0;
         if (found) taken.push_back(d);
      end
      for (int i = 0; i < n; i++) begin
         r.event_index   = i[5:0];
         r.assigned_date = answer_date[i][23:0];
         r.no_free_date  = answer_fail[i];
         r.last_result   = (i == n - 1);
         due_answers.push_back(r);
      end
      set_starts.delete();
      set_ends.delete();
   endtask

   // collect one accepted window, close the set on the last mark or a full set
   task automatic take_window(req_type w);
      set_starts.push_back(w.start_date);
      set_ends.push_back(w.end_date);
      if (w.last_event || set_starts.size() == MAX_EVENTS) assign_dates();
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 45) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: present queued windows, random gaps between transfers
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_payload <= '0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            take_window(req_payload);
            void'(pending_windows.pop_front());
            if (pending_windows.size() > 0 && idle_left == 0 && pick_gap() == 0) begin
               req_payload <= pending_windows[0];
            end else begin
               start <= 1'b0;
               idle_left <= pick_gap();
            end
         end else if (!start) begin
            if (idle_left > 0) idle_left <= idle_left - 1;
            else if (pending_windows.size() > 0) begin
               start <= 1'b1;
               req_payload <= pending_windows[0];
            end
         end
      end
   end

   // monitor: every strobe is one result transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (due_answers.size() == 0) begin
            $error("unexpected result index %0d", rsp_payload.event_index);
            failed = 1'b1;
         end else begin
            rsp_type exp_r;
            exp_r = due_answers.pop_front();
            if (rsp_payload.event_index !== exp_r.event_index) begin
               $error("event_index exp %0d got %0d", exp_r.event_index, rsp_payload.event_index);
               failed = 1'b1;
            end
            if (rsp_payload.assigned_date !== exp_r.assigned_date) begin
               $error("assigned_date exp %0h got %0h", exp_r.assigned_date,
                      rsp_payload.assigned_date);
               failed = 1'b1;
            end
            if (rsp_payload.no_free_date !== exp_r.no_free_date) begin
               $error("no_free_date exp %0b got %0b", exp_r.no_free_date,
                      rsp_payload.no_free_date);
               failed = 1'b1;
            end
            if (rsp_payload.last_result !== exp_r.last_result) begin
               $error("last_result exp %0b got %0b", exp_r.last_result,
                      rsp_payload.last_result);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("interval_distinct_slot_assigner_core test failed");
         $finish;
      end
   end

   function automatic req_type make_window(logic [23:0] s, logic [23:0] e, bit last);
      req_type w;
      w.start_date = s;
      w.end_date   = e;
      w.last_event = last;
      return w;
   endfunction

   // random set: clustered windows so dates collide, sometimes fully random fields
   task automatic queue_random_set(int n, bit no_mark);
      int          base;
      logic [23:0] s;
      logic [23:0] e;
      base = $urandom_range(0, 24'hFFFFFF - 64);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            s = 24'($urandom_range(0, 24'hFFFFFF));
            e = 24'($urandom_range(0, 24'hFFFFFF));
         end else begin
            s = 24'(base + $urandom_range(0, 12));
            e = ($urandom_range(0, 9) == 0) ? 24'(s - 24'd1)
                                            : 24'(s + 24'($urandom_range(0, 6)));
         end
         pending_windows.push_back(make_window(s, e, !no_mark && i == n - 1));
      end
   endtask

   initial begin
      int random_items;
      failed = 1'b0;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      idle_left = 0;

      // directed: single window sets, a wide window, extremes, start after end
      pending_windows.push_back(make_window(24'hFFFFFF, 24'hFFFFFF, 1'b1));
      pending_windows.push_back(make_window(24'h000001, 24'hFFFFFF, 1'b1));
      pending_windows.push_back(make_window(24'h000005, 24'h000004, 1'b1));
      // directed: identical windows, last one finds no free date
      pending_windows.push_back(make_window(24'h000010, 24'h000011, 1'b0));
      pending_windows.push_back(make_window(24'h000010, 24'h000011, 1'b0));
      pending_windows.push_back(make_window(24'h000010, 24'h000011, 1'b1));
      // directed: sort ties on end and start, failed window takes nothing
      pending_windows.push_back(make_window(24'h000030, 24'h000032, 1'b0));
      pending_windows.push_back(make_window(24'h000031, 24'h000031, 1'b0));
      pending_windows.push_back(make_window(24'h000031, 24'h000031, 1'b0));
      pending_windows.push_back(make_window(24'h000030, 24'h000032, 1'b0));
      pending_windows.push_back(make_window(24'h000032, 24'h000030, 1'b1));
      // directed: start date zero, end date zero, top of the date range, start after end
      pending_windows.push_back(make_window(24'h000000, 24'h000000, 1'b0));
      pending_windows.push_back(make_window(24'h000000, 24'h000001, 1'b0));
      pending_windows.push_back(make_window(24'hFFFFFE, 24'hFFFFFF, 1'b0));
      pending_windows.push_back(make_window(24'hFFFFFF, 24'hFFFFFF, 1'b0));
      pending_windows.push_back(make_window(24'hAAAAAA, 24'h555555, 1'b1));

      // random sets, one full set closing without a last mark
      random_items = 0;
      while (random_items < 65) begin
         int n;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         queue_random_set(n, 1'b0);
         random_items += n;
      end
      queue_random_set(MAX_EVENTS, 1'b1);
      queue_random_set(5, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (pending_windows.size() == 0 && !start);
      wait (due_answers.size() == 0);
      repeat (300) @(posedge clock);
      if (!failed && due_answers.size() == 0)
         $display("interval_distinct_slot_assigner_core test passed");
      else
         $display("interval_distinct_slot_assigner_core test failed");
      $finish;
   end
endmodule
